// ----- design/gce_pkg.sv -----
// ----------------------------------------------------------------------------
// gce_pkg
// Shared constants and types of the glyph color expander.
// ----------------------------------------------------------------------------
package gce_pkg;

  // Number of palette entries the block is built with (2 to 256).
  localparam int unsigned PALETTE_ENTRIES = 16;

  // Palette field widths fixed by the item format.
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned PAL_IDX_W = 4;

  // Only entries reachable by a 4-bit index are stored.
  localparam int unsigned PAL_DEPTH =
      (PALETTE_ENTRIES < (1 << PAL_IDX_W)) ? PALETTE_ENTRIES : (1 << PAL_IDX_W);
  localparam int unsigned PAL_AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

  // Configuration port widths and register indexes.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PIXEL_HIGH  = 8'd1;

  // Request type codes.
  localparam logic REQ_GLYPH_ROW = 1'b0;
  localparam logic REQ_PAL_WRITE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [1:0] GLYPH_WIDTH_MODE_RST = 2'd1;
  localparam logic       LEFT_PIXEL_HIGH_RST  = 1'b0;

  // Palette write request from the intake to the palette store.
  typedef struct packed {
    logic                 en;
    logic [PAL_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   color;
  } pal_wr_t;

endpackage

// ----- design/gce_palette.sv -----
// ----------------------------------------------------------------------------
// gce_palette
// Color palette with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gce_palette (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gce_pkg::pal_wr_t                  wr_i,
  input  logic                              rd_en_i,
  input  logic [gce_pkg::PAL_IDX_W-1:0]     fg_idx_i,
  input  logic [gce_pkg::PAL_IDX_W-1:0]     bg_idx_i,
  output logic [gce_pkg::COLOR_W-1:0]       fg_color_o,
  output logic [gce_pkg::COLOR_W-1:0]       bg_color_o
);

  logic [gce_pkg::COLOR_W-1:0] mem_q [gce_pkg::PAL_DEPTH];
  logic [gce_pkg::PAL_DEPTH-1:0] valid_q;
  logic [gce_pkg::COLOR_W-1:0] fg_q, bg_q;

  logic wr_in_range, fg_in_range, bg_in_range;
  logic [gce_pkg::PAL_AW-1:0] wr_addr, fg_addr, bg_addr;

  // Indexes past the stored depth write nothing and read as zero.
  assign wr_in_range = {1'b0, wr_i.idx} < (gce_pkg::PAL_IDX_W+1)'(gce_pkg::PAL_DEPTH);
  assign fg_in_range = {1'b0, fg_idx_i} < (gce_pkg::PAL_IDX_W+1)'(gce_pkg::PAL_DEPTH);
  assign bg_in_range = {1'b0, bg_idx_i} < (gce_pkg::PAL_IDX_W+1)'(gce_pkg::PAL_DEPTH);
  assign wr_addr = wr_i.idx[gce_pkg::PAL_AW-1:0];
  assign fg_addr = fg_idx_i[gce_pkg::PAL_AW-1:0];
  assign bg_addr = bg_idx_i[gce_pkg::PAL_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem_q[wr_addr] <= wr_i.color;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en && wr_in_range) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fg_q <= (fg_in_range && valid_q[fg_addr]) ? mem_q[fg_addr] : '0;
      bg_q <= (bg_in_range && valid_q[bg_addr]) ? mem_q[bg_addr] : '0;
    end
  end

  assign fg_color_o = fg_q;
  assign bg_color_o = bg_q;

endmodule

// ----- design/glyph_color_expander_top.sv -----
// ----------------------------------------------------------------------------
// glyph_color_expander_top
// Expands monochrome font rows into 16-bit-per-pixel words of two pixels.
// ----------------------------------------------------------------------------
// A glyph-row transfer produces 2, 4, 6 or 8 output words (glyph widths 4, 8,
// 12 or 16), one word per cycle unless the receiver stalls, with last_word_o
// set on the final one; the next input item is taken in the cycle that the
// final word is loaded into the output register, so a row holds off further
// input until its final word is loaded. A single word generator walks the
// font row two bits per word. Palette-write transfers give no output; they
// are stored before any later row reads the palette. A palette entry that
// was never written reads as color zero. Configuration writes are accepted
// in every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module glyph_color_expander_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input item channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [15:0]                        font_row_i,
  input  logic [gce_pkg::PAL_IDX_W-1:0]      fg_index_i,
  input  logic [gce_pkg::PAL_IDX_W-1:0]      bg_index_i,
  input  logic [gce_pkg::PAL_IDX_W-1:0]      pal_index_i,
  input  logic [gce_pkg::COLOR_W-1:0]        pal_color_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        pixel_pair_o,
  output logic                               last_word_o,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gce_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [1:0] width_mode_q;
  logic       left_high_q;

  // Job registers of the row being expanded.
  logic        busy_q, busy_d;
  logic [15:0] row_q;
  logic [2:0]  word_q;
  logic [1:0]  job_mode_q;
  logic        job_left_high_q;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] pixel_pair_q;
  logic        last_q;

  logic in_xfer, glyph_xfer, out_load, job_last;
  logic [gce_pkg::COLOR_W-1:0] fg_color, bg_color, left_color, right_color;
  logic [31:0] word;
  gce_pkg::pal_wr_t pal_wr;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q <= gce_pkg::GLYPH_WIDTH_MODE_RST;
      left_high_q  <= gce_pkg::LEFT_PIXEL_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gce_pkg::CFG_GLYPH_WIDTH_MODE: width_mode_q <= cfg_data_i[1:0];
        gce_pkg::CFG_LEFT_PIXEL_HIGH:  left_high_q  <= cfg_data_i[0];
        default: ;  // Writes past the register list are dropped.
      endcase
    end
  end

  // The word generator may be loaded whenever the output register is free
  // or is being emptied in this cycle.
  assign out_load = busy_q && (!out_valid_q || out_ready_i);
  // The final word index is 2 * mode + 1.
  assign job_last = (word_q == {job_mode_q, 1'b1});

  // A new item is taken when no row is in work or the current row is
  // handing over its final word right now.
  assign in_ready_o = !busy_q || (out_load && job_last);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign glyph_xfer = in_xfer && (req_type_i == gce_pkg::REQ_GLYPH_ROW);

  assign pal_wr.en    = in_xfer && (req_type_i == gce_pkg::REQ_PAL_WRITE);
  assign pal_wr.idx   = pal_index_i;
  assign pal_wr.color = pal_color_i;

  // Colors are looked up once, at the transfer of the glyph row, and held
  // in the palette read registers for the whole row.
  gce_palette u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (pal_wr),
    .rd_en_i    (glyph_xfer),
    .fg_idx_i   (fg_index_i),
    .bg_idx_i   (bg_index_i),
    .fg_color_o (fg_color),
    .bg_color_o (bg_color)
  );

  always_comb begin
    busy_d = busy_q;
    if (glyph_xfer) begin
      busy_d = 1'b1;
    end else if (out_load && job_last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // The row shifts left two bits per word, so the current pixel pair always
  // sits in the top two bits.
  always_ff @(posedge clk_i) begin
    if (glyph_xfer) begin
      row_q           <= font_row_i;
      word_q          <= '0;
      job_mode_q      <= width_mode_q;
      job_left_high_q <= left_high_q;
    end else if (out_load) begin
      row_q  <= {row_q[13:0], 2'b00};
      word_q <= word_q + 3'd1;
    end
  end

  assign left_color  = row_q[15] ? fg_color : bg_color;
  assign right_color = row_q[14] ? fg_color : bg_color;
  assign word = job_left_high_q ? {left_color, right_color} : {right_color, left_color};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_pair_q <= word;
      last_q       <= job_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_pair_o = pixel_pair_q;
  assign last_word_o  = last_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph color expander.
// ----------------------------------------------------------------------------
// The bench sends glyph-row and palette-write transfers with random content.
// It keeps its own copy of the palette and of the two configuration
// registers. From these it works out the words that each row should give.
// It compares every output word, field by field, with the oldest word still
// expected. The run goes through every glyph width and both pixel orders,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import gce_pkg::*;

  // Register indexes past the end of the register list. The block must ignore
  // writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

  // Length of the receiver hold-off that fills up the block.
  localparam int unsigned HOLD_OFF_CYCLES = 250;
  // Cycles allowed after the last expected word, so that a trailing palette
  // write has settled.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Hard limit on the run, in nanoseconds. The slowest correct run needs only a
  // small part of this.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 45;
  localparam int unsigned NUM_PHASES = 8;

  // --------------------------------------------------------------------------
  // Expected-word store with its own copy of the palette and the registers.
  // --------------------------------------------------------------------------
  class row_expansion_board;
    typedef struct packed {
      logic [31:0] pair;
      logic        last;
    } word_t;

    logic [COLOR_W-1:0] colors [PALETTE_ENTRIES];
    logic [1:0]         width_mode;
    logic               left_high;
    word_t              expected_words[$];
    int                 errors;

    function new();
      foreach (colors[i]) colors[i] = '0;
      width_mode = GLYPH_WIDTH_MODE_RST;
      left_high  = LEFT_PIXEL_HIGH_RST;
      errors     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_GLYPH_WIDTH_MODE) begin
        width_mode = data[1:0];
      end else if (idx == CFG_LEFT_PIXEL_HIGH) begin
        left_high = data[0];
      end
    endfunction

    // Called for every accepted input transfer, in order of acceptance.
    function void note_input(logic req, logic [15:0] row, logic [PAL_IDX_W-1:0] fg,
                             logic [PAL_IDX_W-1:0] bg, logic [PAL_IDX_W-1:0] pidx,
                             logic [COLOR_W-1:0] pcol);
      int                 words;
      logic [COLOR_W-1:0] fg_c;
      logic [COLOR_W-1:0] bg_c;
      logic [COLOR_W-1:0] lc;
      logic [COLOR_W-1:0] rc;
      word_t              w;
      if (req == REQ_PAL_WRITE) begin
        if (pidx < PALETTE_ENTRIES) colors[pidx] = pcol;
        return;
      end
      fg_c  = (fg < PALETTE_ENTRIES) ? colors[fg] : '0;
      bg_c  = (bg < PALETTE_ENTRIES) ? colors[bg] : '0;
      words = 2 * (int'(width_mode) + 1);
      // Two font bits per word, msb first; unused low bits never get looked at.
      for (int k = 0; k < words; k++) begin
        lc     = row[15 - 2 * k] ? fg_c : bg_c;
        rc     = row[14 - 2 * k] ? fg_c : bg_c;
        w.pair = left_high ? {lc, rc} : {rc, lc};
        w.last = (k == words - 1);
        expected_words.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] pair, logic last);
      word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h last=%b", pair, last));
        return;
      end
      w = expected_words.pop_front();
      if (pair !== w.pair) report($sformatf("pixel_pair %h, expected %h", pair, w.pair));
      if (last !== w.last) report($sformatf("last_word %b, expected %b", last, w.last));
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_GLYPH_ROW;
  logic [15:0]           font_row = '0;
  logic [PAL_IDX_W-1:0]  fg_index = '0;
  logic [PAL_IDX_W-1:0]  bg_index = '0;
  logic [PAL_IDX_W-1:0]  pal_index = '0;
  logic [COLOR_W-1:0]    pal_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           pixel_pair;
  logic                  last_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Receiver behavior. The stall rate and the hold-off flag each have one
  // writer, and both are updated with nonblocking assignments.
  int unsigned rx_stall_pct = 0;
  logic        hold_active = 1'b0;
  // The sender gap rate is only used by the stimulus process.
  int unsigned tx_idle_pct = 0;

  row_expansion_board board = new();

  glyph_color_expander_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .font_row_i   (font_row),
    .fg_index_i   (fg_index),
    .bg_index_i   (bg_index),
    .pal_index_i  (pal_index),
    .pal_color_i  (pal_color),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_pair_o (pixel_pair),
    .last_word_o  (last_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver. At each rising edge it checks the word that transfers at that
  // edge, then picks ready for the next cycle. All inputs are driven with
  // nonblocking assignments, so the values read here are the ones from before
  // the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(pixel_pair, last_word);
    end
    out_ready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender tasks.
  // --------------------------------------------------------------------------

  // Offers one item, after a random gap, and returns at the edge where it
  // transfers. Valid stays high on return, so a following item without a gap
  // goes out back to back.
  task automatic send_item(input logic req, input logic [15:0] row,
                           input logic [PAL_IDX_W-1:0] fg, input logic [PAL_IDX_W-1:0] bg,
                           input logic [PAL_IDX_W-1:0] pidx, input logic [COLOR_W-1:0] pcol);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    font_row  <= row;
    fg_index  <= fg;
    bg_index  <= bg;
    pal_index <= pidx;
    pal_color <= pcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(req, row, fg, bg, pidx, pcol);
  endtask

  // A palette write carries random content in the row fields, which the
  // block must ignore.
  task automatic pal_write(input logic [PAL_IDX_W-1:0] idx, input logic [COLOR_W-1:0] color);
    send_item(REQ_PAL_WRITE, 16'($urandom), PAL_IDX_W'($urandom), PAL_IDX_W'($urandom),
              idx, color);
  endtask

  // A glyph row carries random content in the palette-write fields.
  task automatic glyph_row(input logic [15:0] row, input logic [PAL_IDX_W-1:0] fg,
                           input logic [PAL_IDX_W-1:0] bg);
    send_item(REQ_GLYPH_ROW, row, fg, bg, PAL_IDX_W'($urandom), COLOR_W'($urandom));
  endtask

  // Stops offering items and waits until every expected word has come out.
  // It then lets the block settle, because a palette write leaves nothing
  // behind to wait for.
  task automatic quiesce();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && guard < 50_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Valid drops for a cycle afterwards, so that
  // back-to-back writes never lower and raise it in the same step.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both registers. The unused upper data bits are random, and the
  // block has to drop them.
  task automatic apply_setting(input logic [1:0] mode, input logic lph);
    write_cfg(CFG_GLYPH_WIDTH_MODE, {6'($urandom), mode});
    write_cfg(CFG_LEFT_PIXEL_HIGH, {7'($urandom), lph});
  endtask

  // A random item: about one in five is a palette write. Rows lean a little
  // toward all-clear and all-set fonts.
  task automatic random_item();
    int unsigned pick;
    logic [15:0] row;
    pick = $urandom_range(99);
    if (pick < 20) begin
      pal_write(PAL_IDX_W'($urandom), COLOR_W'($urandom));
    end else begin
      if (pick < 28) row = 16'h0000;
      else if (pick < 36) row = 16'hFFFF;
      else row = 16'($urandom);
      glyph_row(row, PAL_IDX_W'($urandom), PAL_IDX_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  logic [15:0] dir_fonts [8] = '{16'hF00F, 16'h7FFE, 16'hC3A5, 16'h0F0F,
                                 16'h5550, 16'h000F, 16'h8001, 16'hAAAA};
  logic [1:0]  phase_mode [NUM_PHASES] = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
  logic        phase_lph [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with no gaps and no stalls. Writes to register indexes
    // past the list must leave the reset setting (8 pixels, left pixel low)
    // in place.
    write_cfg(CFG_UNUSED_LOW, 8'hFF);
    write_cfg(CFG_UNUSED_TOP, 8'h00);
    // Entries that were never written still read as zero after reset.
    glyph_row(16'hFFFF, 4'd3, 4'd12);
    // Palette extremes: entry 0 and entry 15, all-ones and end-bits-only colors.
    pal_write(4'd0, 16'hFFFF);
    pal_write(4'd15, 16'h8001);
    pal_write(4'd6, 16'h5AA5);
    glyph_row(16'hA5C3, 4'd0, 4'd15);
    // At 8 pixels the low font byte is ignored.
    glyph_row(16'h00FF, 4'd15, 4'd6);
    // Foreground and background both point at the same entry.
    glyph_row(16'h0000, 4'd0, 4'd0);
    // A row that reads the entry written just before it.
    pal_write(4'd4, 16'h1357);
    glyph_row(16'h8001, 4'd4, 4'd0);
    // Every glyph width in both pixel orders. Most of the fonts put set bits in the
    // positions that the narrow widths are meant to ignore.
    for (int m = 0; m < 4; m++) begin
      for (int l = 0; l < 2; l++) begin
        quiesce();
        apply_setting(2'(m), 1'(l));
        glyph_row(dir_fonts[2 * m + l], l ? 4'd15 : 4'd0, l ? 4'd0 : 4'd15);
      end
    end

    // Random part. The idling pattern cycles through four kinds: none,
    // sender gaps, receiver stalls, and both at a lower rate.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      apply_setting(phase_mode[p], phase_lph[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 78;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 78;
        end
        default: begin
          tx_idle_pct = 31;
          rx_stall_pct <= 31;
        end
      endcase
      // In the first phase the receiver holds off for a long stretch while the
      // sender keeps going, so the block fills up and stops taking input.
      if (p == 0) begin
        fork
          begin
            hold_active <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Halfway through one phase the sender waits until the block has
        // drained completely, then starts again.
        if (p == 2 && i == ITEMS_PER_PHASE / 2) quiesce();
        random_item();
      end
    end

    quiesce();
    if (board.pending() != 0) begin
      board.report($sformatf("%0d expected words never came out", board.pending()));
    end
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
design/gce_pkg.sv
design/gce_palette.sv
design/glyph_color_expander_top.sv
bench/tb_top.sv
